// ===== rtl/core/bbpi_pkg.sv =====
// Package for the box bounce particle integrator: shared types, register
// indexes, microcode opcodes and the control store contents.
// No dependencies.
`default_nettype none

package bbpi_pkg;

    localparam int AXES = 3;

    typedef logic signed [31:0] q16_t;
    typedef q16_t [AXES-1:0] vec3_t;

    localparam logic [19:0] WALL_Q16 = 20'd327680;

    typedef enum logic [2:0] {
        REG_ACCEL_X     = 3'd0,
        REG_ACCEL_Y     = 3'd1,
        REG_ACCEL_Z     = 3'd2,
        REG_RESTITUTION = 3'd3,
        REG_RADIUS      = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_MUL_A,
        OP_ADD_V,
        OP_MUL_V,
        OP_ADD_P,
        OP_BOUNCE,
        OP_EMIT
    } op_t;

    typedef logic [3:0] pc_t;
    typedef logic [1:0] axis_t;

    localparam pc_t PC_START = 4'd0;
    localparam pc_t PC_Y     = 4'd5;
    localparam pc_t PC_Z     = 4'd10;
    localparam pc_t PC_EMIT  = 4'd15;

    localparam axis_t AX_X = 2'd0;
    localparam axis_t AX_Y = 2'd1;
    localparam axis_t AX_Z = 2'd2;

    typedef struct packed {
        op_t   op;
        axis_t axis;
        logic  jmp_nohit;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        logic  start;
        logic  load;
        op_t   op;
        axis_t axis;
    } dp_ctrl_t;

    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        w = '{op: OP_EMIT, axis: AX_X, jmp_nohit: 1'b0, target: PC_START};
        case (pc)
            4'd0:  w = '{OP_MUL_A,  AX_X, 1'b0, PC_START};
            4'd1:  w = '{OP_ADD_V,  AX_X, 1'b0, PC_START};
            4'd2:  w = '{OP_MUL_V,  AX_X, 1'b0, PC_START};
            4'd3:  w = '{OP_ADD_P,  AX_X, 1'b1, PC_Y};
            4'd4:  w = '{OP_BOUNCE, AX_X, 1'b0, PC_START};
            4'd5:  w = '{OP_MUL_A,  AX_Y, 1'b0, PC_START};
            4'd6:  w = '{OP_ADD_V,  AX_Y, 1'b0, PC_START};
            4'd7:  w = '{OP_MUL_V,  AX_Y, 1'b0, PC_START};
            4'd8:  w = '{OP_ADD_P,  AX_Y, 1'b1, PC_Z};
            4'd9:  w = '{OP_BOUNCE, AX_Y, 1'b0, PC_START};
            4'd10: w = '{OP_MUL_A,  AX_Z, 1'b0, PC_START};
            4'd11: w = '{OP_ADD_V,  AX_Z, 1'b0, PC_START};
            4'd12: w = '{OP_MUL_V,  AX_Z, 1'b0, PC_START};
            4'd13: w = '{OP_ADD_P,  AX_Z, 1'b1, PC_EMIT};
            4'd14: w = '{OP_BOUNCE, AX_Z, 1'b0, PC_START};
            default: w = '{OP_EMIT, AX_X, 1'b0, PC_START};
        endcase
        return w;
    endfunction

    function automatic q16_t sat32(input logic signed [34:0] v);
        q16_t r;
        if (v > 35'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -35'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bbpi_if.sv =====
// Channel interfaces of the box bounce particle integrator: command items in,
// state results out. Depends on bbpi_pkg.
`default_nettype none

interface bbpi_cmd_if;
    import bbpi_pkg::*;

    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] time_step;
    q16_t        load_pos_x;
    q16_t        load_pos_y;
    q16_t        load_pos_z;
    q16_t        load_vel_x;
    q16_t        load_vel_y;
    q16_t        load_vel_z;

    modport source (
        output valid, action, time_step,
        output load_pos_x, load_pos_y, load_pos_z,
        output load_vel_x, load_vel_y, load_vel_z,
        input  ready
    );
    modport sink (
        input  valid, action, time_step,
        input  load_pos_x, load_pos_y, load_pos_z,
        input  load_vel_x, load_vel_y, load_vel_z,
        output ready
    );
endinterface

interface bbpi_res_if;
    import bbpi_pkg::*;

    logic       valid;
    logic       ready;
    q16_t       pos_x;
    q16_t       pos_y;
    q16_t       pos_z;
    q16_t       vel_x;
    q16_t       vel_y;
    q16_t       vel_z;
    logic [2:0] wall_hits;

    modport source (
        output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, wall_hits,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, wall_hits,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/bbpi_datapath.sv =====
// Datapath of the box bounce particle integrator: position and velocity state,
// the shared multiplier with its product register, rounding, saturation and
// wall clamp. Driven one control word per cycle. Depends on bbpi_pkg.
`default_nettype none

module bbpi_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bbpi_pkg::dp_ctrl_t ctrl,
    input  wire logic [15:0]      dt,
    input  wire bbpi_pkg::vec3_t  accel,
    input  wire logic [15:0]      restitution,
    input  wire logic [18:0]      radius,
    input  wire bbpi_pkg::vec3_t  load_pos,
    input  wire bbpi_pkg::vec3_t  load_vel,
    output bbpi_pkg::vec3_t       pos,
    output bbpi_pkg::vec3_t       vel,
    output logic                  hit,
    output logic [2:0]            hits
);
    import bbpi_pkg::*;

    vec3_t               pos_reg;
    vec3_t               vel_reg;
    logic [2:0]          hits_reg;
    logic signed [48:0]  prod_reg;
    logic signed [48:0]  prod_next;

    q16_t                mul_a;
    logic signed [16:0]  mul_b;
    logic signed [33:0]  rnd16;
    logic signed [33:0]  rnd15;
    q16_t                cur_v;
    q16_t                cur_p;
    q16_t                v_sum;
    q16_t                p_sum;
    q16_t                p_final;
    q16_t                bounce;
    logic [19:0]         r_clip;
    logic [19:0]         limit;
    logic signed [33:0]  lim_s;
    logic signed [33:0]  p34;
    logic                hit_hi;
    logic                hit_lo;

    always_comb
    begin
        cur_v = vel_reg[ctrl.axis];
        cur_p = pos_reg[ctrl.axis];
        mul_a = (ctrl.op == OP_MUL_A) ? accel[ctrl.axis] : cur_v;
        mul_b = (ctrl.op == OP_ADD_P) ? $signed({1'b0, restitution})
                                      : $signed({1'b0, dt});
        prod_next = 49'(mul_a) * 49'(mul_b);

        rnd16 = 34'((prod_reg + 49'sd32768) >>> 16);
        rnd15 = 34'((prod_reg + 49'sd16384) >>> 15);

        v_sum  = sat32(35'(cur_v) + 35'(rnd16));
        p_sum  = sat32(35'(cur_p) + 35'(rnd16));
        bounce = sat32(-35'(rnd15));

        r_clip = ({1'b0, radius} > WALL_Q16) ? WALL_Q16 : {1'b0, radius};
        limit  = WALL_Q16 - r_clip;
        lim_s  = $signed({14'd0, limit});
        p34    = 34'(p_sum);
        hit_hi = p34 > lim_s;
        hit_lo = p34 < -lim_s;
        if (hit_hi)
            p_final = 32'(lim_s);
        else if (hit_lo)
            p_final = 32'(-lim_s);
        else
            p_final = p_sum;
    end

    assign hit  = hit_hi | hit_lo;
    assign pos  = pos_reg;
    assign vel  = vel_reg;
    assign hits = hits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            vel_reg  <= '0;
            hits_reg <= '0;
        end
        else if (ctrl.load)
        begin
            pos_reg  <= load_pos;
            vel_reg  <= load_vel;
            hits_reg <= '0;
        end
        else if (ctrl.start)
        begin
            hits_reg <= '0;
        end
        else
        begin
            case (ctrl.op)
                OP_ADD_V:
                begin
                    vel_reg[ctrl.axis] <= v_sum;
                end
                OP_ADD_P:
                begin
                    pos_reg[ctrl.axis] <= p_final;
                    if (hit)
                        hits_reg[ctrl.axis] <= 1'b1;
                end
                OP_BOUNCE:
                begin
                    vel_reg[ctrl.axis] <= bounce;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_MUL_A || ctrl.op == OP_MUL_V || ctrl.op == OP_ADD_P)
            prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/box_bounce_particle_integrator.sv =====
// Box bounce particle integrator: a sphere inside a cube of half-size 5.0,
// advanced by semi-implicit Euler steps in Q16.16 with wall clamp and bounce.
// A load transaction goes straight to the emit step. An advance
// transaction runs a 16-entry microcode program over one shared 32x17
// multiplier: four steps per axis, five when that axis bounces, then one emit
// step. The result is written into an output register when the emit step
// fires, and no new transaction is taken before then. The emit step waits
// only while a previous result is still not taken.
// Depends on bbpi_pkg, bbpi_if and bbpi_datapath.
`default_nettype none

module box_bounce_particle_integrator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    bbpi_cmd_if.sink         cmd,
    bbpi_res_if.source       res
);
    import bbpi_pkg::*;

    vec3_t       accel_reg;
    logic [15:0] restitution_reg;
    logic [18:0] radius_reg;

    logic        busy_reg;
    logic        busy_next;
    pc_t         pc_reg;
    pc_t         pc_next;
    logic [15:0] dt_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    vec3_t       out_pos_reg;
    vec3_t       out_vel_reg;
    logic [2:0]  out_hits_reg;

    uword_t      uw;
    dp_ctrl_t    ctrl;
    logic        accept;
    logic        emit_fire;
    vec3_t       dp_pos;
    vec3_t       dp_vel;
    logic        dp_hit;
    logic [2:0]  dp_hits;
    vec3_t       load_pos;
    vec3_t       load_vel;

    assign cmd.ready = !busy_reg;
    assign accept    = cmd.valid && !busy_reg;
    assign uw        = ucode(pc_reg);
    assign emit_fire = busy_reg && uw.op == OP_EMIT && (!out_valid_reg || res.ready);

    assign load_pos = {cmd.load_pos_z, cmd.load_pos_y, cmd.load_pos_x};
    assign load_vel = {cmd.load_vel_z, cmd.load_vel_y, cmd.load_vel_x};

    always_comb
    begin
        ctrl.start = accept && !cmd.action;
        ctrl.load  = accept && cmd.action;
        ctrl.op    = busy_reg ? uw.op : OP_EMIT;
        ctrl.axis  = uw.axis;
    end

    bbpi_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .dt          (dt_reg),
        .accel       (accel_reg),
        .restitution (restitution_reg),
        .radius      (radius_reg),
        .load_pos    (load_pos),
        .load_vel    (load_vel),
        .pos         (dp_pos),
        .vel         (dp_vel),
        .hit         (dp_hit),
        .hits        (dp_hits)
    );

    // advance the step counter; branch past the bounce step when no wall is hit
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = cmd.action ? PC_EMIT : PC_START;
        end
        else if (busy_reg)
        begin
            if (uw.op == OP_EMIT)
            begin
                if (emit_fire)
                begin
                    busy_next = 1'b0;
                    pc_next   = PC_START;
                end
            end
            else if (uw.jmp_nohit && !dp_hit)
                pc_next = uw.target;
            else
                pc_next = pc_reg + 4'd1;
        end
    end

    always_comb
    begin
        if (emit_fire)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= PC_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            dt_reg <= cmd.time_step;
        if (emit_fire)
        begin
            out_pos_reg  <= dp_pos;
            out_vel_reg  <= dp_vel;
            out_hits_reg <= dp_hits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg       <= '0;
            restitution_reg <= 16'd32768;
            radius_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACCEL_X:     accel_reg[AX_X]  <= cfg_data;
                REG_ACCEL_Y:     accel_reg[AX_Y]  <= cfg_data;
                REG_ACCEL_Z:     accel_reg[AX_Z]  <= cfg_data;
                REG_RESTITUTION: restitution_reg  <= cfg_data[15:0];
                REG_RADIUS:      radius_reg       <= cfg_data[18:0];
                default:
                begin
                end
            endcase
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.pos_x     = out_pos_reg[AX_X];
    assign res.pos_y     = out_pos_reg[AX_Y];
    assign res.pos_z     = out_pos_reg[AX_Z];
    assign res.vel_x     = out_vel_reg[AX_X];
    assign res.vel_y     = out_vel_reg[AX_Y];
    assign res.vel_z     = out_vel_reg[AX_Z];
    assign res.wall_hits = out_hits_reg;

    a_load_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.action |=> busy_reg && pc_reg == PC_EMIT)
        else $error("load transaction did not go straight to emit");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && uw.op == OP_EMIT && out_valid_reg && !res.ready
        |=> busy_reg && pc_reg == PC_EMIT)
        else $error("emit step left while output slot was full");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg) && $past(uw.op == OP_EMIT))
        else $error("result raised outside the emit step");

    a_skip_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && uw.jmp_nohit && !dp_hit |=> pc_reg == $past(uw.target))
        else $error("no-hit branch not taken");

endmodule

`default_nettype wire
